// ===== rtl/core/crcfr_pkg.sv =====
// Package for the CRC-16 framed packet receiver: frame geometry, header codes,
// register indexes, the drain state type and the per-byte CRC update function.
// Depends on nothing; the frame buffer, the core and the testbench import it.
package crcfr_pkg;

   // Frame geometry.
   localparam int FRAME_LEN = 18;
   localparam int POS_W     = $clog2(FRAME_LEN);
   localparam int ADDR_W    = POS_W + 1;
   localparam int OUT_BYTES = 15;
   localparam int DRAIN_W   = $clog2(OUT_BYTES);
   localparam int CRC_W     = 16;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from the word address bit.
   localparam logic REG_CRC_SEED = 1'b0;
   localparam logic REG_CRC_POLY = 1'b1;

   // Register reset values.
   localparam logic [CRC_W-1:0] CRC_SEED_RESET = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY_RESET = 16'h8408;

   // Header byte codes.
   localparam logic [7:0] HDR_FF = 8'd255;
   localparam logic [7:0] HDR_FE = 8'd254;
   localparam logic [7:0] HDR_FD = 8'd253;
   localparam logic [7:0] HDR_AA = 8'd170;
   localparam logic [7:0] HDR_BB = 8'd187;

   typedef logic [7:0] byte_type;

   typedef enum logic {
      DRAIN_IDLE,
      DRAIN_READ
   } drain_state_type;

   // True for a byte that opens a frame.
   function automatic logic is_header(input byte_type b);
      return b inside {HDR_FF, HDR_FE, HDR_FD, HDR_AA, HDR_BB};
   endfunction

   // One reflected table CRC step: the table entry is worked out bit by bit.
   function automatic logic [CRC_W-1:0] crc_byte_update(input logic [CRC_W-1:0] crc,
                                                        input byte_type          b,
                                                        input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] t;
      t = {8'h00, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         if (t[0]) begin
            t = (t >> 1) ^ poly;
         end else begin
            t = t >> 1;
         end
      end
      return (crc >> 8) ^ t;
   endfunction

endpackage

// ===== rtl/core/crcfr_req_if.sv =====
// Input channel of the framed receiver: one received byte per transaction.
// Depends on nothing.
interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/crcfr_rsp_if.sv =====
// Result channel of the framed receiver: the decoded fields of one good frame.
// Depends on nothing.
interface crcfr_rsp_if;
   logic               valid;
   logic               ready;
   logic        [7:0]  header_byte;
   logic signed [15:0] word_at_1;
   logic signed [15:0] word_at_3;
   logic signed [15:0] word_at_5;
   logic signed [15:0] word_at_7;
   logic signed [15:0] word_at_9;
   logic        [7:0]  byte_at_11;
   logic        [7:0]  byte_at_12;
   logic signed [15:0] word_at_13;

   modport source (output valid, output header_byte, output word_at_1, output word_at_3,
                   output word_at_5, output word_at_7, output word_at_9,
                   output byte_at_11, output byte_at_12, output word_at_13, input ready);
   modport sink   (input valid, input header_byte, input word_at_1, input word_at_3,
                   input word_at_5, input word_at_7, input word_at_9,
                   input byte_at_11, input byte_at_12, input word_at_13, output ready);
endinterface

// ===== rtl/core/crcfr_frame_buf.sv =====
// Two-bank frame buffer: one bank collects the incoming frame while the other
// is read out. One write port, one read port with registered read data.
// Depends on crcfr_pkg.
module crcfr_frame_buf (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         wr_bank,
   input  logic [crcfr_pkg::POS_W-1:0]  wr_pos,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic                         rd_bank,
   input  logic [crcfr_pkg::POS_W-1:0]  rd_pos,
   output logic [7:0]                   rd_data
);
   import crcfr_pkg::*;

   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_data_ff;

   // Write the received byte at its bank and frame position.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_bank, wr_pos}] <= wr_data;
      end
   end

   // Synchronous read; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[{rd_bank, rd_pos}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/crc16_framed_packet_receiver_core.sv =====
// Top level of the CRC-16 framed packet receiver.
// Depends on crcfr_pkg, crcfr_req_if, crcfr_rsp_if and crcfr_frame_buf.
//
// The req channel takes one received serial byte per transaction. While no
// frame is open, bytes other than a header code are dropped. A header opens
// an 18-byte frame whose bytes 0 to 15 run through a reflected CRC-16 that
// starts at crc_seed; bytes 16 and 17 must hold that CRC, low byte first.
// A good frame yields one rsp transaction with the header, the big-endian
// signed words and the two single bytes; a bad frame is dropped silently.
// Bytes are taken one per cycle while req.ready is high; each good frame moves
// collection to the other bank of the frame buffer. A good frame's bank is
// read out one byte a cycle; rsp.valid rises once its last byte is captured and
// the next frame fills the other bank, so frames sustain one byte per cycle.
// If the rsp side stalls, one result waits in the output register and up to
// two more good frames wait in the banks; req.ready falls only when the bank
// due to collect the next byte still holds an unread frame.
// Reset (synchronous, active high) closes any open frame, empties both banks
// and the output register, and restores crc_seed to 0xFFFF and
// crc_poly_reflected to 0x8408.
module crc16_framed_packet_receiver_core (
   input  logic                                clock,
   input  logic                                reset,
   crcfr_req_if.sink                           req,
   crcfr_rsp_if.source                         rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crcfr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [crcfr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [crcfr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import crcfr_pkg::*;

   localparam logic [POS_W-1:0]   POS_CRC_END = POS_W'(FRAME_LEN - 2);
   localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(FRAME_LEN - 1);
   localparam logic [DRAIN_W-1:0] DRAIN_LAST  = DRAIN_W'(OUT_BYTES - 1);

   // Configuration registers.
   logic [CRC_W-1:0] crc_seed_ff;
   logic [CRC_W-1:0] crc_poly_ff;

   // Frame collection state.
   logic             in_frame_ff;
   logic [POS_W-1:0] byte_count_ff;
   logic [CRC_W-1:0] running_crc_ff;
   byte_type         last_byte_ff;
   logic             wr_bank_ff;
   logic [1:0]       pending_ff;
   logic [1:0]       pending_in;

   // Readout state.
   drain_state_type  drain_state_ff;
   drain_state_type  drain_state_in;
   logic [DRAIN_W-1:0] drain_idx_ff;
   logic [DRAIN_W-1:0] drain_idx_in;
   logic             rd_bank_ff;
   logic             cap_valid_ff;
   logic [DRAIN_W-1:0] cap_idx_ff;
   byte_type         out_bytes_ff [OUT_BYTES];
   logic             rsp_valid_ff;

   logic             req_fire;
   logic             take;
   logic [POS_W-1:0] pos;
   logic [CRC_W-1:0] crc_base;
   logic [CRC_W-1:0] crc_next;
   logic             frame_end;
   logic             crc_pass;
   logic             rd_en;
   byte_type         rd_data;
   logic             cap_last;
   logic             csr_write;

   // Configuration port: writes complete in the access phase, no wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_CRC_SEED: prdata = CSR_DATA_W'(crc_seed_ff);
         REG_CRC_POLY: prdata = CSR_DATA_W'(crc_poly_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_seed_ff <= CRC_SEED_RESET;
         crc_poly_ff <= CRC_POLY_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_CRC_SEED: crc_seed_ff <= pwdata[CRC_W-1:0];
            REG_CRC_POLY: crc_poly_ff <= pwdata[CRC_W-1:0];
            default: ;
         endcase
      end
   end

   // Input side: a byte is stored when a frame is open or it opens one.
   assign req.ready = !pending_ff[wr_bank_ff];
   assign req_fire  = req.valid && req.ready;
   assign take      = req_fire && (in_frame_ff || is_header(req.rx_byte));
   assign pos       = in_frame_ff ? byte_count_ff : '0;
   assign crc_base  = in_frame_ff ? running_crc_ff : crc_seed_ff;
   assign crc_next  = crc_byte_update(crc_base, req.rx_byte, crc_poly_ff);
   assign frame_end = take && (pos == POS_LAST);

   // The CRC is final by the last byte; byte 16 sits in last_byte_ff.
   assign crc_pass  = (running_crc_ff[7:0] == last_byte_ff) &&
                      (running_crc_ff[15:8] == req.rx_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= '0;
         wr_bank_ff    <= 1'b0;
      end else if (take) begin
         if (frame_end) begin
            in_frame_ff   <= 1'b0;
            byte_count_ff <= '0;
            if (crc_pass) begin
               wr_bank_ff <= !wr_bank_ff;
            end
         end else begin
            in_frame_ff   <= 1'b1;
            byte_count_ff <= pos + POS_W'(1);
         end
      end
   end

   // Running CRC over bytes 0 to 15; the previous byte carries no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CRC_SEED_RESET;
      end else if (take && (pos < POS_CRC_END)) begin
         running_crc_ff <= crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         last_byte_ff <= req.rx_byte;
      end
   end

   // Bank ownership: a good frame marks its bank, a finished readout frees it.
   always_comb begin
      pending_in = pending_ff;
      if (frame_end && crc_pass) begin
         pending_in[wr_bank_ff] = 1'b1;
      end
      if (cap_last) begin
         pending_in[rd_bank_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Readout sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_state_ff <= DRAIN_IDLE;
         drain_idx_ff   <= '0;
      end else begin
         drain_state_ff <= drain_state_in;
         drain_idx_ff   <= drain_idx_in;
      end
   end

   // Readout sequencer: reads bytes 0 to 14 of a good frame once the output
   // register is free.
   always_comb begin
      drain_state_in = drain_state_ff;
      drain_idx_in   = drain_idx_ff;
      rd_en          = 1'b0;
      case (drain_state_ff)
         DRAIN_IDLE: begin
            drain_idx_in = '0;
            if (pending_ff[rd_bank_ff] && !rsp_valid_ff && !cap_valid_ff) begin
               drain_state_in = DRAIN_READ;
            end
         end
         DRAIN_READ: begin
            rd_en        = 1'b1;
            drain_idx_in = drain_idx_ff + DRAIN_W'(1);
            if (drain_idx_ff == DRAIN_LAST) begin
               drain_state_in = DRAIN_IDLE;
               drain_idx_in   = '0;
            end
         end
         default: begin
            drain_state_in = DRAIN_IDLE;
            drain_idx_in   = '0;
         end
      endcase
   end

   crcfr_frame_buf u_frame_buf (
      .clock   (clock),
      .wr_en   (take),
      .wr_bank (wr_bank_ff),
      .wr_pos  (pos),
      .wr_data (req.rx_byte),
      .rd_en   (rd_en),
      .rd_bank (rd_bank_ff),
      .rd_pos  (POS_W'(drain_idx_ff)),
      .rd_data (rd_data)
   );

   // Read data lands in the cycle after the read; track which byte it is.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cap_idx_ff <= drain_idx_ff;
   end

   assign cap_last = cap_valid_ff && (cap_idx_ff == DRAIN_LAST);

   always_ff @(posedge clock) begin
      if (cap_valid_ff) begin
         out_bytes_ff[cap_idx_ff] <= rd_data;
      end
   end

   // Bank pointer for readout follows the collection order.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_bank_ff <= 1'b0;
      end else if (cap_last) begin
         rd_bank_ff <= !rd_bank_ff;
      end
   end

   // Output register: set when the last byte is captured, cleared on transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cap_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.header_byte = out_bytes_ff[0];
   assign rsp.word_at_1   = {out_bytes_ff[1], out_bytes_ff[2]};
   assign rsp.word_at_3   = {out_bytes_ff[3], out_bytes_ff[4]};
   assign rsp.word_at_5   = {out_bytes_ff[5], out_bytes_ff[6]};
   assign rsp.word_at_7   = {out_bytes_ff[7], out_bytes_ff[8]};
   assign rsp.word_at_9   = {out_bytes_ff[9], out_bytes_ff[10]};
   assign rsp.byte_at_11  = out_bytes_ff[11];
   assign rsp.byte_at_12  = out_bytes_ff[12];
   assign rsp.word_at_13  = {out_bytes_ff[13], out_bytes_ff[14]};

endmodule

// ===== dv/crc16_framed_packet_receiver_core_tb.sv =====
// Self-checking testbench for the CRC-16 framed packet receiver core.
// Drives serial bytes and register writes, predicts the decoded good frames.
// Depends on crcfr_pkg, crcfr_req_if, crcfr_rsp_if and the core itself.
module crc16_framed_packet_receiver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crcfr_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = {REG_CRC_SEED, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] POLY_ADDR = {REG_CRC_POLY, 2'b00};

   typedef struct {
      byte_type           header_byte;
      logic signed [15:0] word_at_1;
      logic signed [15:0] word_at_3;
      logic signed [15:0] word_at_5;
      logic signed [15:0] word_at_7;
      logic signed [15:0] word_at_9;
      byte_type           byte_at_11;
      byte_type           byte_at_12;
      logic signed [15:0] word_at_13;
   } frame_fields_type;

   // A directed row sends a literal byte or the matching half of the frame CRC.
   typedef enum {ROW_DATA, ROW_CRC_LO, ROW_CRC_HI} row_kind_type;
   typedef enum {WANT_ANY, WANT_NONE, WANT_ONE} row_want_type;

   typedef struct {
      row_kind_type kind;
      byte_type     value;
      row_want_type want;
   } stim_row_type;

   localparam int N_ROWS = 24;

   // Noise while idle, one good frame with extreme fields and embedded header
   // codes, then a frame left open so the next register writes land mid-frame.
   stim_row_type directed_rows [N_ROWS] = '{
      '{ROW_DATA,   8'h00,  WANT_NONE},
      '{ROW_DATA,   8'hFC,  WANT_NONE},
      '{ROW_DATA,   8'h55,  WANT_NONE},
      '{ROW_DATA,   HDR_FF, WANT_NONE},
      '{ROW_DATA,   8'h80,  WANT_NONE},
      '{ROW_DATA,   8'h00,  WANT_NONE},
      '{ROW_DATA,   8'h7F,  WANT_NONE},
      '{ROW_DATA,   8'hFF,  WANT_NONE},
      '{ROW_DATA,   8'hFF,  WANT_NONE},
      '{ROW_DATA,   8'hFF,  WANT_NONE},
      '{ROW_DATA,   8'h00,  WANT_NONE},
      '{ROW_DATA,   8'h00,  WANT_NONE},
      '{ROW_DATA,   HDR_AA, WANT_NONE},
      '{ROW_DATA,   HDR_BB, WANT_NONE},
      '{ROW_DATA,   8'h00,  WANT_NONE},
      '{ROW_DATA,   8'hFF,  WANT_NONE},
      '{ROW_DATA,   HDR_FE, WANT_NONE},
      '{ROW_DATA,   HDR_FD, WANT_NONE},
      '{ROW_DATA,   8'h01,  WANT_NONE},
      '{ROW_CRC_LO, 8'h00,  WANT_NONE},
      '{ROW_CRC_HI, 8'h00,  WANT_ONE},
      '{ROW_DATA,   HDR_BB, WANT_NONE},
      '{ROW_DATA,   8'h01,  WANT_NONE},
      '{ROW_DATA,   8'h80,  WANT_ANY}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   crcfr_req_if req_bus();
   crcfr_rsp_if rsp_bus();

   crc16_framed_packet_receiver_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state and its copy of the registers.
   logic [CRC_W-1:0] cfg_seed;
   logic [CRC_W-1:0] cfg_poly;
   logic [CRC_W-1:0] crc_lut [256];
   bit               pr_in_frame;
   int               pr_count;
   logic [CRC_W-1:0] pr_crc;
   byte_type         pr_bytes [FRAME_LEN];

   frame_fields_type frames_due [$];
   int               mismatches;
   int               cycle_count;
   int               idle_pct;
   byte_type         spoil_lo;
   byte_type         spoil_hi;

   always #2 clock = ~clock;

   // Run limit, in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic bit header_code(byte_type b);
      case (b)
         HDR_FF, HDR_FE, HDR_FD, HDR_AA, HDR_BB: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Byte table of the reflected CRC for the current polynomial.
   function automatic void build_crc_lut();
      logic [CRC_W-1:0] t;
      for (int i = 0; i < 256; i++) begin
         t = CRC_W'(i);
         for (int k = 0; k < 8; k++) begin
            t = t[0] ? ((t >> 1) ^ cfg_poly) : (t >> 1);
         end
         crc_lut[i] = t;
      end
   endfunction

   // Advances the predicted receiver by one accepted byte; queues a decoded
   // frame when the byte completes a frame whose CRC matches.
   function automatic bit absorb_byte(byte_type b);
      frame_fields_type f;
      int               pos;
      if (!pr_in_frame) begin
         if (!header_code(b)) begin
            return 1'b0;
         end
         pr_in_frame = 1'b1;
         pr_count    = 0;
         pr_crc      = cfg_seed;
      end
      pos = (pr_count >= FRAME_LEN) ? FRAME_LEN - 1 : pr_count;
      pr_bytes[pos] = b;
      if (pos < FRAME_LEN - 2) begin
         pr_crc = (pr_crc >> 8) ^ crc_lut[pr_crc[7:0] ^ b];
      end
      if (pos + 1 < FRAME_LEN) begin
         pr_count = pos + 1;
         return 1'b0;
      end
      pr_in_frame = 1'b0;
      pr_count    = 0;
      if (pr_crc != {pr_bytes[FRAME_LEN-1], pr_bytes[FRAME_LEN-2]}) begin
         return 1'b0;
      end
      f.header_byte = pr_bytes[0];
      f.word_at_1   = {pr_bytes[1], pr_bytes[2]};
      f.word_at_3   = {pr_bytes[3], pr_bytes[4]};
      f.word_at_5   = {pr_bytes[5], pr_bytes[6]};
      f.word_at_7   = {pr_bytes[7], pr_bytes[8]};
      f.word_at_9   = {pr_bytes[9], pr_bytes[10]};
      f.byte_at_11  = pr_bytes[11];
      f.byte_at_12  = pr_bytes[12];
      f.word_at_13  = {pr_bytes[13], pr_bytes[14]};
      frames_due.push_back(f);
      return 1'b1;
   endfunction

   function automatic byte_type pick_header();
      case ($urandom_range(0, 4))
         0: return HDR_FF;
         1: return HDR_FE;
         2: return HDR_FD;
         3: return HDR_AA;
         default: return HDR_BB;
      endcase
   endfunction

   // Next random byte: mostly well-formed frames, some with a spoiled CRC,
   // with noise between frames and header codes sprinkled into the payload.
   function automatic byte_type pick_byte();
      if (!pr_in_frame) begin
         if ($urandom_range(0, 9) == 0) begin
            return byte_type'($urandom);
         end
         spoil_lo = 8'h00;
         spoil_hi = 8'h00;
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
               0: spoil_lo = byte_type'($urandom_range(1, 255));
               1: spoil_hi = byte_type'($urandom_range(1, 255));
               default: begin
                  spoil_lo = byte_type'($urandom_range(1, 255));
                  spoil_hi = byte_type'($urandom_range(1, 255));
               end
            endcase
         end
         return pick_header();
      end
      if (pr_count == FRAME_LEN - 2) begin
         return pr_crc[7:0] ^ spoil_lo;
      end
      if (pr_count == FRAME_LEN - 1) begin
         return pr_crc[15:8] ^ spoil_hi;
      end
      if ($urandom_range(0, 7) == 0) begin
         return pick_header();
      end
      return byte_type'($urandom);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result monitor: every result transaction is matched to the oldest frame.
   always @(posedge clock) begin
      frame_fields_type f;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frames_due.size() == 0) begin
            $error("result transaction with no frame expected");
            mismatches++;
         end else begin
            f = frames_due.pop_front();
            check_field("header_byte", 16'(f.header_byte), 16'(rsp_bus.header_byte));
            check_field("word_at_1", f.word_at_1, rsp_bus.word_at_1);
            check_field("word_at_3", f.word_at_3, rsp_bus.word_at_3);
            check_field("word_at_5", f.word_at_5, rsp_bus.word_at_5);
            check_field("word_at_7", f.word_at_7, rsp_bus.word_at_7);
            check_field("word_at_9", f.word_at_9, rsp_bus.word_at_9);
            check_field("byte_at_11", 16'(f.byte_at_11), 16'(rsp_bus.byte_at_11));
            check_field("byte_at_12", 16'(f.byte_at_12), 16'(rsp_bus.byte_at_12));
            check_field("word_at_13", f.word_at_13, rsp_bus.word_at_13);
         end
      end
   end

   // Result side backpressure: random stall bursts, then runs of ready.
   always begin
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // All tasks below start and end just after a falling edge.
   task automatic send_byte(byte_type b, output bit produced);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      produced = absorb_byte(b);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == SEED_ADDR) begin
         cfg_seed = data[CRC_W-1:0];
      end else begin
         cfg_poly = data[CRC_W-1:0];
         build_crc_lut();
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Reads a register back and compares it with the predictor's copy.
   task automatic csr_check(logic [CSR_ADDR_W-1:0] addr, logic [CRC_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[CRC_W-1:0] !== want) begin
         $error("prdata at %0h: expected %h, got %h", addr, want, got[CRC_W-1:0]);
         mismatches++;
      end
   endtask

   // Waits until every predicted frame has come out, then lets the block settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Random traffic; stops mid-frame when asked so the following register
   // writes fall inside an open frame.
   task automatic run_random(int n_items, bit end_in_frame);
      byte_type b;
      bit       produced;
      int       sent;
      sent = 0;
      while (sent < n_items || (end_in_frame && !pr_in_frame)) begin
         b = pick_byte();
         if (pr_in_frame || header_code(b)) begin
            sent++;
         end
         send_byte(b, produced);
      end
   endtask

   logic [CSR_DATA_W-1:0] seed_words [4];
   logic [CSR_DATA_W-1:0] poly_words [4];
   int                    phase_idle [4];

   initial begin
      byte_type b;
      bit       produced;

      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      idle_pct        = 0;
      mismatches      = 0;
      cycle_count     = 0;
      spoil_lo        = 8'h00;
      spoil_hi        = 8'h00;

      // Extremes first, then values wider than a register, then a random one, then the reset values.
      seed_words = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_FFFF};
      poly_words = '{32'h0000_0000, 32'hABCD_FFFF, $urandom, 32'h0000_8408};
      phase_idle = '{25, 50, 10, 0};

      cfg_seed    = CRC_SEED_RESET;
      cfg_poly    = CRC_POLY_RESET;
      pr_in_frame = 1'b0;
      pr_count    = 0;
      pr_crc      = CRC_SEED_RESET;
      build_crc_lut();

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_check(SEED_ADDR, CRC_SEED_RESET);
      csr_check(POLY_ADDR, CRC_POLY_RESET);

      // Directed rows with the reset register values.
      for (int i = 0; i < N_ROWS; i++) begin
         case (directed_rows[i].kind)
            ROW_CRC_LO: b = pr_crc[7:0];
            ROW_CRC_HI: b = pr_crc[15:8];
            default:    b = directed_rows[i].value;
         endcase
         send_byte(b, produced);
         if ((directed_rows[i].want == WANT_NONE && produced) ||
             (directed_rows[i].want == WANT_ONE && !produced)) begin
            $error("directed row %0d: expected %s, predicted %0d results",
                   i, directed_rows[i].want.name(), produced);
            mismatches++;
         end
      end

      // Random phases, each under its own register setting.
      for (int p = 0; p < 4; p++) begin
         idle_pct = 0;
         drain_results();
         csr_write(SEED_ADDR, seed_words[p]);
         csr_write(POLY_ADDR, poly_words[p]);
         csr_check(SEED_ADDR, cfg_seed);
         csr_check(POLY_ADDR, cfg_poly);
         idle_pct = phase_idle[p];
         if (p < 3) begin
            run_random(150, 1'b1);
         end else begin
            run_random(250, 1'b0);
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
